// ===== sv/htr_pkg.sv =====
// Shared constants, codes and types of the heater temperature regulator.
// No dependencies; every other file refers to this package by scoped names.
package htr_pkg;

    localparam int HEATER_COUNT = 4;
    localparam int HIDX_W       = (HEATER_COUNT > 1) ? $clog2(HEATER_COUNT) : 1;

    localparam logic [1:0] REQ_TICK       = 2'd0;
    localparam logic [1:0] REQ_SET_TARGET = 2'd1;
    localparam logic [1:0] REQ_SET_SENSOR = 2'd2;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_SENSOR_ERR = 2'd1;
    localparam logic [1:0] ST_SKIP       = 2'd2;
    localparam logic [1:0] ST_BAD_HEATER = 2'd3;

    localparam logic [2:0] CFG_GAIN_P   = 3'd0;
    localparam logic [2:0] CFG_GAIN_I   = 3'd1;
    localparam logic [2:0] CFG_GAIN_D   = 3'd2;
    localparam logic [2:0] CFG_DUTY_MAX = 3'd3;
    localparam logic [2:0] CFG_DUTY_MIN = 3'd4;
    localparam logic [2:0] CFG_MODE     = 3'd5;
    localparam logic [2:0] CFG_BAND     = 3'd6;

    localparam logic [23:0] GAIN_P_RST   = 24'd534016;
    localparam logic [15:0] DUTY_MAX_RST = 16'hFFFF;
    localparam logic [9:0]  BAND_RST     = 10'd10;

    localparam logic [15:0] READ_ERR_LOW  = 16'h0000;
    localparam logic [15:0] READ_ERR_HIGH = 16'hFFFF;
    localparam logic [15:0] FULL_ON       = 16'hFFFF;
    localparam logic        MODE_BANG     = 1'b1;

    typedef struct packed {
        logic [23:0] gain_p;
        logic [23:0] gain_i;
        logic [23:0] gain_d;
        logic [15:0] duty_max;
        logic [15:0] duty_min;
        logic        mode;
        logic [9:0]  band;
    } t_cfg;

    typedef struct packed {
        logic [15:0] target;
        logic        sensor;
        logic [15:0] duty;
        logic [23:0] integ;
        logic [15:0] prev;
    } t_entry;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  heater;
        logic [15:0] measured;
        logic [15:0] target_value;
        logic        sensor_present;
    } t_req;

    typedef struct packed {
        logic              en;
        logic [HIDX_W-1:0] idx;
        t_entry            data;
    } t_wr;

    typedef struct packed {
        logic [15:0] duty;
        logic        duty_write;
        logic [1:0]  status;
    } t_result;

endpackage

// ===== sv/htr_cfg_regs.sv =====
// Configuration register file: gains, duty clamps, mode and hysteresis band.
// Depends on htr_pkg.
module htr_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_valid,
    input  logic [2:0]    i_cfg_index,
    input  logic [23:0]   i_cfg_data,
    output htr_pkg::t_cfg o_cfg
);

    htr_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p   <= htr_pkg::GAIN_P_RST;
            r_cfg.gain_i   <= '0;
            r_cfg.gain_d   <= '0;
            r_cfg.duty_max <= htr_pkg::DUTY_MAX_RST;
            r_cfg.duty_min <= '0;
            r_cfg.mode     <= 1'b0;
            r_cfg.band     <= htr_pkg::BAND_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                htr_pkg::CFG_GAIN_P:   r_cfg.gain_p   <= i_cfg_data;
                htr_pkg::CFG_GAIN_I:   r_cfg.gain_i   <= i_cfg_data;
                htr_pkg::CFG_GAIN_D:   r_cfg.gain_d   <= i_cfg_data;
                htr_pkg::CFG_DUTY_MAX: r_cfg.duty_max <= i_cfg_data[15:0];
                htr_pkg::CFG_DUTY_MIN: r_cfg.duty_min <= i_cfg_data[15:0];
                htr_pkg::CFG_MODE:     r_cfg.mode     <= i_cfg_data[0];
                htr_pkg::CFG_BAND:     r_cfg.band     <= i_cfg_data[9:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== sv/htr_state_store.sv =====
// Per-heater state memory: one word per heater, one read and one write port.
// Read data registered; entries never written read as zero. Depends on htr_pkg.
module htr_state_store (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_rd_en,
    input  logic [htr_pkg::HIDX_W-1:0] i_rd_idx,
    output htr_pkg::t_entry            o_rd_data,
    input  htr_pkg::t_wr               i_wr
);

    localparam int ENTRY_W = $bits(htr_pkg::t_entry);

    logic [ENTRY_W-1:0]               r_mem [htr_pkg::HEATER_COUNT];
    logic [htr_pkg::HEATER_COUNT-1:0] r_valid;
    logic [ENTRY_W-1:0]               r_rd_data;
    logic                             r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.idx] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.idx] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_idx];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? htr_pkg::t_entry'(r_rd_data) : '0;

endmodule

// ===== sv/htr_pipe.sv =====
// Five-stage update pipeline: classify, PID multiplies and clamps, bang-bang,
// result and state write-back. Depends on htr_pkg.
module htr_pipe (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic             i_load,
    input  htr_pkg::t_req    i_req,
    input  htr_pkg::t_entry  i_entry,
    input  htr_pkg::t_cfg    i_cfg,
    output logic             o_hazard,
    output logic             o_valid,
    output htr_pkg::t_result o_result,
    output htr_pkg::t_wr     o_wr
);

    typedef enum logic [2:0] {
        OP_BAD,
        OP_SET_TARGET,
        OP_SET_SENSOR,
        OP_IGNORE,
        OP_SKIP,
        OP_SENSOR_ERR,
        OP_RUN
    } t_op;

    typedef struct packed {
        t_op             op;
        logic [7:0]      heater;
        logic [15:0]     measured;
        logic [15:0]     target_value;
        logic            sensor_present;
        htr_pkg::t_entry entry;
        logic [15:0]     bb_duty;
    } t_item;

    logic                r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid, r_s5_valid;
    htr_pkg::t_req       r_s1_req;
    t_item               r_s2_item, r_s3_item, r_s4_item, r_s5_item;
    logic signed [16:0]  r_s2_err, r_s2_chg, r_s3_err, r_s3_chg, r_s4_chg;
    logic signed [41:0]  r_s3_pi, r_s4_pp, r_s5_pd;
    logic [23:0]         r_s4_nic, r_s5_nic;
    logic signed [42:0]  r_s5_sum;

    t_item               n_s2_item;
    logic signed [16:0]  n_s2_err, n_s2_chg;
    logic [16:0]         w_band;
    logic signed [41:0]  n_s3_pi, n_s4_pp, n_s5_pd;
    logic signed [42:0]  w_ni;
    logic [23:0]         w_top24, n_s4_nic;
    logic signed [42:0]  n_s5_sum;
    logic signed [43:0]  w_out, w_top, w_bot;
    logic [15:0]         w_pid_duty, w_new_duty;
    logic                w_keep_i;
    htr_pkg::t_entry     w_wr_entry;
    logic                w_wr_en;

    // stage 1: classify, bang-bang decision and form differences
    always_comb begin
        n_s2_item.heater         = r_s1_req.heater;
        n_s2_item.measured       = r_s1_req.measured;
        n_s2_item.target_value   = r_s1_req.target_value;
        n_s2_item.sensor_present = r_s1_req.sensor_present;
        n_s2_item.entry          = i_entry;
        w_band = {7'd0, i_cfg.band};

        priority if (r_s1_req.heater >= 8'(htr_pkg::HEATER_COUNT)) begin
            n_s2_item.op = OP_BAD;
        end else if (r_s1_req.req_type == htr_pkg::REQ_SET_TARGET) begin
            n_s2_item.op = OP_SET_TARGET;
        end else if (r_s1_req.req_type == htr_pkg::REQ_SET_SENSOR) begin
            n_s2_item.op = OP_SET_SENSOR;
        end else if (r_s1_req.req_type != htr_pkg::REQ_TICK) begin
            n_s2_item.op = OP_IGNORE;
        end else if (i_entry.target == '0 || !i_entry.sensor) begin
            n_s2_item.op = OP_SKIP;
        end else if (r_s1_req.measured == htr_pkg::READ_ERR_LOW
                     || r_s1_req.measured == htr_pkg::READ_ERR_HIGH) begin
            n_s2_item.op = OP_SENSOR_ERR;
        end else begin
            n_s2_item.op = OP_RUN;
        end

        priority if ({1'b0, r_s1_req.measured} > {1'b0, i_entry.target} + w_band) begin
            n_s2_item.bb_duty = '0;
        end else if ({1'b0, r_s1_req.measured} + w_band < {1'b0, i_entry.target}) begin
            n_s2_item.bb_duty = htr_pkg::FULL_ON;
        end else begin
            n_s2_item.bb_duty = i_entry.duty;
        end

        n_s2_err = $signed({1'b0, i_entry.target} - {1'b0, r_s1_req.measured});
        n_s2_chg = $signed({1'b0, r_s1_req.measured} - {1'b0, i_entry.prev});
    end

    // stage 2: integral product
    assign n_s3_pi = r_s2_err * $signed({1'b0, i_cfg.gain_i});

    // stage 3: clamp integral, proportional product
    assign w_top24 = {i_cfg.duty_max, 8'h00};
    assign w_ni    = $signed({19'd0, r_s3_item.entry.integ}) + $signed({r_s3_pi[41], r_s3_pi});
    assign n_s4_pp = r_s3_err * $signed({1'b0, i_cfg.gain_p});

    always_comb begin
        priority if (w_ni > $signed({19'd0, w_top24})) begin
            n_s4_nic = w_top24;
        end else if (w_ni[42]) begin
            n_s4_nic = '0;
        end else begin
            n_s4_nic = w_ni[23:0];
        end
    end

    // stage 4: derivative product, partial sum
    assign n_s5_pd  = r_s4_chg * $signed({1'b0, i_cfg.gain_d});
    assign n_s5_sum = $signed({r_s4_pp[41], r_s4_pp}) + $signed({19'd0, r_s4_nic});

    // stage 5: output clamp, result and write-back
    assign w_out = $signed({r_s5_sum[42], r_s5_sum}) - $signed({{2{r_s5_pd[41]}}, r_s5_pd});
    assign w_top = $signed({20'd0, i_cfg.duty_max, 8'h00});
    assign w_bot = $signed({20'd0, i_cfg.duty_min, 8'h00});

    always_comb begin
        priority if (w_out >= w_top) begin
            w_pid_duty = i_cfg.duty_max;
            w_keep_i   = 1'b0;
        end else if (w_out < w_bot) begin
            w_pid_duty = i_cfg.duty_min;
            w_keep_i   = 1'b0;
        end else begin
            w_pid_duty = w_out[23:8];
            w_keep_i   = 1'b1;
        end
        w_new_duty = (i_cfg.mode == htr_pkg::MODE_BANG) ? r_s5_item.bb_duty : w_pid_duty;
    end

    always_comb begin
        w_wr_entry = r_s5_item.entry;
        w_wr_en    = 1'b0;
        o_result   = '{duty: 16'd0, duty_write: 1'b0, status: htr_pkg::ST_SKIP};
        unique case (r_s5_item.op)
            OP_BAD: begin
                o_result.status = htr_pkg::ST_BAD_HEATER;
            end
            OP_SET_TARGET: begin
                w_wr_entry.target = r_s5_item.target_value;
                w_wr_en           = 1'b1;
            end
            OP_SET_SENSOR: begin
                w_wr_entry.sensor = r_s5_item.sensor_present;
                w_wr_en           = 1'b1;
            end
            OP_IGNORE: begin
            end
            OP_SKIP: begin
                o_result.duty = r_s5_item.entry.duty;
            end
            OP_SENSOR_ERR: begin
                o_result.duty_write = 1'b1;
                o_result.status     = htr_pkg::ST_SENSOR_ERR;
            end
            OP_RUN: begin
                w_wr_entry.duty = w_new_duty;
                if (i_cfg.mode != htr_pkg::MODE_BANG) begin
                    w_wr_entry.prev = r_s5_item.measured;
                    if (w_keep_i) begin
                        w_wr_entry.integ = r_s5_nic;
                    end
                end
                w_wr_en             = 1'b1;
                o_result.duty       = w_new_duty;
                o_result.duty_write = (w_new_duty != r_s5_item.entry.duty);
                o_result.status     = htr_pkg::ST_OK;
            end
            default: begin
            end
        endcase
    end

    assign o_wr.en   = i_adv && r_s5_valid && w_wr_en;
    assign o_wr.idx  = r_s5_item.heater[htr_pkg::HIDX_W-1:0];
    assign o_wr.data = w_wr_entry;
    assign o_valid   = r_s5_valid;

    // hold a request whose heater still has an update in flight
    assign o_hazard = (r_s1_valid && r_s1_req.heater == i_req.heater)
                   || (r_s2_valid && r_s2_item.heater == i_req.heater)
                   || (r_s3_valid && r_s3_item.heater == i_req.heater)
                   || (r_s4_valid && r_s4_item.heater == i_req.heater)
                   || (r_s5_valid && r_s5_item.heater == i_req.heater);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_s5_valid <= 1'b0;
        end else if (i_adv) begin
            r_s1_valid <= i_load;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
            r_s5_valid <= r_s4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s1_req  <= i_req;
            r_s2_item <= n_s2_item;
            r_s2_err  <= n_s2_err;
            r_s2_chg  <= n_s2_chg;
            r_s3_item <= r_s2_item;
            r_s3_err  <= r_s2_err;
            r_s3_chg  <= r_s2_chg;
            r_s3_pi   <= n_s3_pi;
            r_s4_item <= r_s3_item;
            r_s4_chg  <= r_s3_chg;
            r_s4_nic  <= n_s4_nic;
            r_s4_pp   <= n_s4_pp;
            r_s5_item <= r_s4_item;
            r_s5_nic  <= r_s4_nic;
            r_s5_sum  <= n_s5_sum;
            r_s5_pd   <= n_s5_pd;
        end
    end

endmodule

// ===== sv/heater_temperature_regulator.sv =====
// Heater temperature regulator top level: stream ports, config port, output register.
// Path: each request passes through pipeline registers s1 to s5, then the output register.
// Throughput: one request per cycle while the output is not held back and no request
// addresses a heater that still has an update in flight; such a request waits until
// that update is written back to the state memory.
// Reset: synchronous, active low; config returns to defaults, all heater state reads zero.
// Depends on htr_pkg, htr_cfg_regs, htr_state_store, htr_pipe.
module heater_temperature_regulator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] heater, [23:8] measured, [39:24] target_value, [40] sensor_present
    input  logic [47:0] s_axis_tdata,
    // [1:0] req_type
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] duty, [16] duty_write
    output logic [23:0] m_axis_tdata,
    // [1:0] status
    output logic [1:0]  m_axis_tuser,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);

    htr_pkg::t_cfg    w_cfg;
    htr_pkg::t_req    w_req;
    htr_pkg::t_entry  w_entry;
    htr_pkg::t_wr     w_wr;
    htr_pkg::t_result w_result;
    htr_pkg::t_result r_out;
    logic             r_out_valid;
    logic             w_adv, w_hazard, w_accept, w_rd_en, w_s5_valid;

    assign w_req.req_type       = s_axis_tuser;
    assign w_req.heater         = s_axis_tdata[7:0];
    assign w_req.measured       = s_axis_tdata[23:8];
    assign w_req.target_value   = s_axis_tdata[39:24];
    assign w_req.sensor_present = s_axis_tdata[40];

    assign o_cfg_ready   = 1'b1;
    assign w_adv         = !r_out_valid || m_axis_tready;
    assign s_axis_tready = w_adv && !w_hazard;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_rd_en       = w_accept && (w_req.heater < 8'(htr_pkg::HEATER_COUNT));

    htr_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    htr_state_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_rd_en),
        .i_rd_idx  (w_req.heater[htr_pkg::HIDX_W-1:0]),
        .o_rd_data (w_entry),
        .i_wr      (w_wr)
    );

    htr_pipe u_pipe (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_load   (w_accept),
        .i_req    (w_req),
        .i_entry  (w_entry),
        .i_cfg    (w_cfg),
        .o_hazard (w_hazard),
        .o_valid  (w_s5_valid),
        .o_result (w_result),
        .o_wr     (w_wr)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_s5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out.duty_write, r_out.duty};
    assign m_axis_tuser  = r_out.status;

endmodule

// ===== tb/sv/heater_temperature_regulator_checker.sv =====
// Checker for the heater temperature regulator: watches the request, result and config
// channels, predicts each result from its own copy of the heater state and compares it.
// Depends on htr_pkg for the request, result and config types and codes.
`timescale 1ns / 1ps

module heater_temperature_regulator_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    // [7:0] heater, [23:8] measured, [39:24] target_value, [40] sensor_present
    input  logic [47:0] s_axis_tdata,
    // [1:0] req_type
    input  logic [1:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] duty, [16] duty_write
    input  logic [23:0] m_axis_tdata,
    // [1:0] status
    input  logic [1:0]  m_axis_tuser,
    input  logic        i_cfg_valid,
    input  logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int PRINT_LIMIT = 40;

    htr_pkg::t_cfg    reg_copy;
    htr_pkg::t_entry  heater_state [htr_pkg::HEATER_COUNT];
    htr_pkg::t_result duty_expect_q [$];
    int               fail_total = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        if (fail_total < PRINT_LIMIT)
            $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
        fail_total++;
    endtask

    function automatic logic [15:0] pid_duty(input int h, input logic [15:0] meas);
        longint tgt, rd, prev, integ, gp, gi, gd, top, bot;
        longint err, chg, ni, acc;
        logic [15:0] res;
        tgt   = heater_state[h].target;
        rd    = meas;
        prev  = heater_state[h].prev;
        integ = heater_state[h].integ;
        gp    = reg_copy.gain_p;
        gi    = reg_copy.gain_i;
        gd    = reg_copy.gain_d;
        top   = reg_copy.duty_max;
        bot   = reg_copy.duty_min;
        top   = top * 256;
        bot   = bot * 256;
        err   = tgt - rd;
        chg   = rd - prev;
        ni    = integ + err * gi;
        if (ni > top)
            ni = top;
        else if (ni < 0)
            ni = 0;
        acc = err * gp + ni - chg * gd;
        if (acc >= top) begin
            res = reg_copy.duty_max;
        end else if (acc < bot) begin
            res = reg_copy.duty_min;
        end else begin
            res = acc[23:8];
            heater_state[h].integ = ni[23:0];
        end
        heater_state[h].prev = meas;
        return res;
    endfunction

    function automatic logic [15:0] bang_duty(input int h, input logic [15:0] meas);
        int tgt, rd, band;
        tgt  = heater_state[h].target;
        rd   = meas;
        band = reg_copy.band;
        if (rd > tgt + band)
            return 16'd0;
        if (rd < tgt - band)
            return htr_pkg::FULL_ON;
        return heater_state[h].duty;
    endfunction

    function automatic htr_pkg::t_result regulate(input htr_pkg::t_req r);
        htr_pkg::t_result res;
        logic [15:0] nd;
        int h;
        res.duty       = 16'd0;
        res.duty_write = 1'b0;
        res.status     = htr_pkg::ST_SKIP;
        h = r.heater;
        if (r.heater >= htr_pkg::HEATER_COUNT) begin
            res.status = htr_pkg::ST_BAD_HEATER;
        end else if (r.req_type == htr_pkg::REQ_SET_TARGET) begin
            heater_state[h].target = r.target_value;
        end else if (r.req_type == htr_pkg::REQ_SET_SENSOR) begin
            heater_state[h].sensor = r.sensor_present;
        end else if (r.req_type == htr_pkg::REQ_TICK) begin
            if (heater_state[h].target == 16'd0 || !heater_state[h].sensor) begin
                res.duty = heater_state[h].duty;
            end else if (r.measured == htr_pkg::READ_ERR_LOW ||
                         r.measured == htr_pkg::READ_ERR_HIGH) begin
                res.duty_write = 1'b1;
                res.status     = htr_pkg::ST_SENSOR_ERR;
            end else begin
                if (reg_copy.mode == htr_pkg::MODE_BANG)
                    nd = bang_duty(h, r.measured);
                else
                    nd = pid_duty(h, r.measured);
                res.duty_write = (nd != heater_state[h].duty);
                heater_state[h].duty = nd;
                res.duty   = nd;
                res.status = htr_pkg::ST_OK;
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        htr_pkg::t_result got, want;
        htr_pkg::t_req    req;
        if (!i_rst_n) begin
            reg_copy.gain_p   = htr_pkg::GAIN_P_RST;
            reg_copy.gain_i   = '0;
            reg_copy.gain_d   = '0;
            reg_copy.duty_max = htr_pkg::DUTY_MAX_RST;
            reg_copy.duty_min = '0;
            reg_copy.mode     = '0;
            reg_copy.band     = htr_pkg::BAND_RST;
            for (int i = 0; i < htr_pkg::HEATER_COUNT; i++)
                heater_state[i] = '0;
            duty_expect_q.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.duty       = m_axis_tdata[15:0];
                got.duty_write = m_axis_tdata[16];
                got.status     = m_axis_tuser;
                if (duty_expect_q.size() == 0) begin
                    report_mismatch("result transfer with none expected, duty", got.duty, -1);
                end else begin
                    want = duty_expect_q.pop_front();
                    if (got.duty != want.duty)
                        report_mismatch("duty", got.duty, want.duty);
                    if (got.duty_write != want.duty_write)
                        report_mismatch("duty_write", got.duty_write, want.duty_write);
                    if (got.status != want.status)
                        report_mismatch("status", got.status, want.status);
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    htr_pkg::CFG_GAIN_P:   reg_copy.gain_p   = i_cfg_data;
                    htr_pkg::CFG_GAIN_I:   reg_copy.gain_i   = i_cfg_data;
                    htr_pkg::CFG_GAIN_D:   reg_copy.gain_d   = i_cfg_data;
                    htr_pkg::CFG_DUTY_MAX: reg_copy.duty_max = i_cfg_data[15:0];
                    htr_pkg::CFG_DUTY_MIN: reg_copy.duty_min = i_cfg_data[15:0];
                    htr_pkg::CFG_MODE:     reg_copy.mode     = i_cfg_data[0];
                    htr_pkg::CFG_BAND:     reg_copy.band     = i_cfg_data[9:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                req.req_type       = s_axis_tuser;
                req.heater         = s_axis_tdata[7:0];
                req.measured       = s_axis_tdata[23:8];
                req.target_value   = s_axis_tdata[39:24];
                req.sensor_present = s_axis_tdata[40];
                duty_expect_q.push_back(regulate(req));
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= duty_expect_q.size();
    end

endmodule

// ===== tb/sv/heater_temperature_regulator_tb.sv =====
// Testbench top for the heater temperature regulator: clock, reset, request stimulus,
// config phases and result back-pressure; checking is left to the checker module.
// Depends on htr_pkg, heater_temperature_regulator and heater_temperature_regulator_checker.
`timescale 1ns / 1ps

module heater_temperature_regulator_tb;

    localparam logic [1:0] REQ_UNUSED   = 2'd3;
    localparam int         WATCHDOG_MAX = 4000;
    localparam int         DRAIN_CYCLES = 10;
    localparam int         PHASE_ITEMS  = 65;

    localparam int IDLE_NONE = 0;
    localparam int IDLE_SRC  = 1;
    localparam int IDLE_SINK = 2;
    localparam int IDLE_BOTH = 3;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index   = '0;
    logic [23:0] i_cfg_data    = '0;

    int          fail_count;
    int          pending;
    int          src_idle_pct   = 0;
    int          sink_stall_pct = 0;
    int          read_span      = 300;
    int          quiet_cycles   = 0;
    logic [15:0] target_hint [htr_pkg::HEATER_COUNT] = '{default: 16'd0};

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    heater_temperature_regulator u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    heater_temperature_regulator_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("heater_temperature_regulator_tb NOT OK");
            $finish;
        end
    end

    task automatic send_req(input logic [1:0] kind, input logic [7:0] hn,
                            input logic [15:0] meas, input logic [15:0] tval,
                            input logic sp);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, sp, tval, meas, hn};
        s_axis_tuser  <= kind;
        if (kind == htr_pkg::REQ_SET_TARGET && hn < htr_pkg::HEATER_COUNT)
            target_hint[hn] = tval;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic write_cfg(input logic [2:0] idx, input logic [23:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_idle(input int mode);
        case (mode)
            IDLE_SRC:  begin src_idle_pct = 51; sink_stall_pct <= 0;  end
            IDLE_SINK: begin src_idle_pct = 0;  sink_stall_pct <= 51; end
            IDLE_BOTH: begin src_idle_pct = 36; sink_stall_pct <= 36; end
            default:   begin src_idle_pct = 0;  sink_stall_pct <= 0;  end
        endcase
    endtask

    task automatic send_random_req();
        logic [1:0]  kind;
        logic [7:0]  hn;
        logic [15:0] meas, tval;
        logic        sp;
        int          pick, mv;
        kind = 2'($urandom_range(3));
        hn   = 8'($urandom);
        meas = 16'($urandom);
        tval = 16'($urandom);
        sp   = 1'($urandom);
        pick = $urandom_range(99);
        if (pick < 62) begin
            kind = htr_pkg::REQ_TICK;
            hn   = 8'($urandom_range(htr_pkg::HEATER_COUNT - 1));
            if (pick < 52) begin
                mv = int'(target_hint[hn]) + $urandom_range(2 * read_span) - read_span;
                if (mv < 1)
                    mv = 1;
                if (mv > 65534)
                    mv = 65534;
                meas = 16'(mv);
            end else if (pick < 57) begin
                meas = $urandom_range(1) ? htr_pkg::READ_ERR_LOW : htr_pkg::READ_ERR_HIGH;
            end
        end else if (pick < 76) begin
            kind = htr_pkg::REQ_SET_TARGET;
            hn   = 8'($urandom_range(htr_pkg::HEATER_COUNT - 1));
            if ($urandom_range(19) == 0)
                tval = 16'd0;
            else if ($urandom_range(3) != 0)
                tval = 16'($urandom_range(65000, 200));
        end else if (pick < 86) begin
            kind = htr_pkg::REQ_SET_SENSOR;
            hn   = 8'($urandom_range(htr_pkg::HEATER_COUNT - 1));
            sp   = ($urandom_range(4) != 0);
        end else if (pick < 94) begin
            hn = 8'($urandom_range(255, htr_pkg::HEATER_COUNT));
        end else begin
            kind = REQ_UNUSED;
        end
        send_req(kind, hn, meas, tval, sp);
    endtask

    task automatic run_phase(input int idle_mode, input htr_pkg::t_cfg c, input int span);
        write_cfg(htr_pkg::CFG_GAIN_P,   c.gain_p);
        write_cfg(htr_pkg::CFG_GAIN_I,   c.gain_i);
        write_cfg(htr_pkg::CFG_GAIN_D,   c.gain_d);
        write_cfg(htr_pkg::CFG_DUTY_MAX, {8'd0, c.duty_max});
        write_cfg(htr_pkg::CFG_DUTY_MIN, {8'd0, c.duty_min});
        write_cfg(htr_pkg::CFG_MODE,     {23'd0, c.mode});
        write_cfg(htr_pkg::CFG_BAND,     {14'd0, c.band});
        set_idle(idle_mode);
        read_span = span;
        repeat (PHASE_ITEMS) send_random_req();
        drain();
    endtask

    initial begin
        htr_pkg::t_cfg c;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: PID with the default proportional gain
        send_req(htr_pkg::REQ_TICK,       8'd0,   16'd300,   16'd0,     1'b0);
        send_req(htr_pkg::REQ_SET_TARGET, 8'd0,   16'd0,     16'hFFFF,  1'b0);
        send_req(htr_pkg::REQ_TICK,       8'd0,   16'd300,   16'd0,     1'b0);
        send_req(htr_pkg::REQ_SET_SENSOR, 8'd0,   16'd0,     16'd0,     1'b1);
        send_req(htr_pkg::REQ_TICK,       8'd0,   htr_pkg::READ_ERR_LOW,  16'd0, 1'b0);
        send_req(htr_pkg::REQ_TICK,       8'd0,   htr_pkg::READ_ERR_HIGH, 16'd0, 1'b0);
        send_req(htr_pkg::REQ_TICK,       8'd0,   16'd1,     16'd0,     1'b0);
        send_req(htr_pkg::REQ_TICK,       8'd0,   16'd65534, 16'd0,     1'b0);
        send_req(htr_pkg::REQ_SET_TARGET, 8'd1,   16'd0,     16'd1,     1'b0);
        send_req(htr_pkg::REQ_SET_SENSOR, 8'd1,   16'd0,     16'd0,     1'b1);
        send_req(htr_pkg::REQ_TICK,       8'd1,   16'd65534, 16'd0,     1'b0);
        send_req(htr_pkg::REQ_TICK,       8'd1,   16'd1,     16'd0,     1'b0);
        send_req(htr_pkg::REQ_SET_SENSOR, 8'd0,   16'd0,     16'd0,     1'b0);
        send_req(htr_pkg::REQ_TICK,       8'd0,   16'd500,   16'd0,     1'b0);
        send_req(htr_pkg::REQ_SET_TARGET, 8'd2,   16'd0,     16'hAAAA,  1'b0);
        send_req(htr_pkg::REQ_SET_SENSOR, 8'd2,   16'd0,     16'd0,     1'b1);
        send_req(htr_pkg::REQ_TICK,       8'd2,   16'h5555,  16'd0,     1'b0);
        send_req(htr_pkg::REQ_SET_TARGET, 8'd3,   16'd0,     16'd1000,  1'b0);
        send_req(htr_pkg::REQ_SET_SENSOR, 8'd3,   16'd0,     16'd0,     1'b1);
        send_req(htr_pkg::REQ_TICK,       8'd3,   16'd990,   16'd0,     1'b0);
        send_req(htr_pkg::REQ_TICK,       8'd255, 16'd900,   16'hFFFF,  1'b1);
        send_req(htr_pkg::REQ_SET_TARGET, 8'd4,   16'd0,     16'hFFFF,  1'b1);
        send_req(REQ_UNUSED,              8'd2,   16'd700,   16'd700,   1'b1);
        send_req(REQ_UNUSED,              8'd128, 16'hFFFF,  16'hFFFF,  1'b1);
        send_req(htr_pkg::REQ_SET_TARGET, 8'd1,   16'd0,     16'd0,     1'b0);
        send_req(htr_pkg::REQ_TICK,       8'd1,   16'd400,   16'd0,     1'b0);
        repeat (PHASE_ITEMS) send_random_req();
        drain();

        run_phase(IDLE_SRC, '{gain_p: 24'd256, gain_i: 24'd16, gain_d: 24'd64,
                  duty_max: 16'd60000, duty_min: 16'd100, mode: 1'b0, band: 10'd10}, 300);
        run_phase(IDLE_SINK, '{gain_p: 24'hFFFFFF, gain_i: 24'hFFFFFF, gain_d: 24'hFFFFFF,
                  duty_max: 16'hFFFF, duty_min: 16'd0, mode: 1'b0, band: 10'h3FF}, 300);
        run_phase(IDLE_BOTH, '{gain_p: 24'd0, gain_i: 24'd0, gain_d: 24'd0,
                  duty_max: 16'd0, duty_min: 16'd0, mode: 1'b0, band: 10'd0}, 300);
        run_phase(IDLE_NONE, '{gain_p: 24'd512, gain_i: 24'd0, gain_d: 24'd0,
                  duty_max: 16'hFFFF, duty_min: 16'd0, mode: htr_pkg::MODE_BANG,
                  band: 10'd0}, 5);
        run_phase(IDLE_SRC, '{gain_p: 24'd512, gain_i: 24'd8, gain_d: 24'd0,
                  duty_max: 16'hFFFF, duty_min: 16'd0, mode: htr_pkg::MODE_BANG,
                  band: 10'h3FF}, 1500);
        // lower clamp above the upper one
        run_phase(IDLE_SINK, '{gain_p: 24'd300, gain_i: 24'd40, gain_d: 24'd20,
                  duty_max: 16'd1000, duty_min: 16'd5000, mode: 1'b0, band: 10'd10}, 300);

        c.gain_p   = 24'($urandom_range(2048));
        c.gain_i   = 24'($urandom_range(256));
        c.gain_d   = 24'($urandom_range(512));
        c.duty_max = 16'($urandom_range(65535, 20000));
        c.duty_min = 16'($urandom_range(2000));
        c.mode     = 1'($urandom_range(1));
        c.band     = 10'($urandom_range(1023));
        run_phase(IDLE_BOTH, c, 400);

        if (fail_count == 0 && pending == 0)
            $display("heater_temperature_regulator_tb OK");
        else
            $display("heater_temperature_regulator_tb NOT OK");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/htr_pkg.sv
sv/htr_cfg_regs.sv
sv/htr_state_store.sv
sv/htr_pipe.sv
sv/heater_temperature_regulator.sv
tb/sv/heater_temperature_regulator_checker.sv
tb/sv/heater_temperature_regulator_tb.sv
